// ----- hdl/prrs_pkg.sv -----
// ----------------------------------------------------------------------------
// prrs_pkg
// Shared constants and types for the priority round-robin scheduler.
// ----------------------------------------------------------------------------
package prrs_pkg;
  localparam int THREAD_SLOTS    = 32;
  localparam int PRIORITY_LEVELS = 8;
  localparam int SW = $clog2(THREAD_SLOTS);
  localparam int PW = $clog2(PRIORITY_LEVELS);

  typedef logic [2:0] mode_t;
  localparam mode_t M_ADD = 3'd0, M_KILL = 3'd1, M_SLEEP = 3'd2, M_BLOCK = 3'd3,
                    M_UNBLOCK = 3'd4, M_TICK = 3'd5, M_SCHED = 3'd6, M_NOP = 3'd7;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK = 3'd0, ST_FULL = 3'd1, ST_BLOCKED = 3'd2,
                      ST_NONE = 3'd3, ST_NORUN = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH,
    S_ADD_SCAN, S_ADD_HEAD, S_ADD_TAIL, S_ADD_LINK,
    S_KILL_RD, S_KILL_LINK,
    S_RUN_RD, S_RUN_WR,
    S_UNB_SCAN, S_UNB_WR,
    S_TICK_RD, S_TICK_WR,
    S_SCH_LVL, S_SCH_RD, S_SCH_CHK,
    S_DONE
  } state_t;
endpackage

// ----- hdl/priority_round_robin_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler_top
// Hardware thread scheduler over a slot table held in block memories.
// ----------------------------------------------------------------------------
// One command is taken at a time; each returns one result item. The slot
// table (used, priority, sleep, blocked mark, ring links) lives in memories
// with registered reads, walked by a sequencer. Every command passes a
// dispatch state and a done state beside its own work: add scans for the
// lowest free slot and links it into its ring (head, tail and link steps
// when the ring is not empty), tick reads and rewrites every slot in turn,
// unblock scans all slots, schedule enters the levels in priority order
// and visits the slots of each ring, and kill, sleep and block work on the
// running slot. After reset the attribute memory (used, priority, sleep,
// blocked) is cleared in a pass over all slots, during which no item is
// taken. The result waits in an output register and no new item is taken
// until it has been accepted.
module priority_round_robin_scheduler_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_mode,
  input  logic [2:0]               in_priority_req,
  input  logic [30:0]              in_sleep_time,
  input  logic [7:0]               in_sema_id,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               out_status,
  output logic [4:0]               out_slot,
  output logic [31:0]              out_thread_id,
  output logic [4:0]               out_running_slot,
  output logic                     out_running_valid
);
  import prrs_pkg::*;

  // slot attribute memory: used, prio, sleep, blocked
  typedef struct packed {
    logic          used;
    logic [PW-1:0] prio;
    logic [30:0]   sleep;
    logic [7:0]    blk;
  } attr_t;
  typedef struct packed {
    logic [SW-1:0] nxt;
    logic [SW-1:0] prv;
  } link_t;

  attr_t attr_mem [THREAD_SLOTS];
  link_t link_mem [THREAD_SLOTS];

  logic          a_we, l_we;
  logic [SW-1:0] a_wa, a_ra, l_wa, l_ra;
  attr_t         a_wd, a_rd;
  link_t         l_wd, l_rd;

  always_ff @(posedge clk) begin
    if (a_we) attr_mem[a_wa] <= a_wd;
    a_rd <= attr_mem[a_ra];
  end
  always_ff @(posedge clk) begin
    if (l_we) link_mem[l_wa] <= l_wd;
    l_rd <= link_mem[l_ra];
  end

  state_t state_r, state_nxt;
  logic [SW:0]   idx_r, idx_nxt;
  logic          clr_r, clr_nxt;
  logic [2:0]    mode_r, mode_nxt;
  logic [PW-1:0] prio_r, prio_nxt;
  logic [30:0]   stime_r, stime_nxt;
  logic [7:0]    sema_r, sema_nxt;
  logic [SW-1:0] s_r, s_nxt, t_r, t_nxt, start_r, start_nxt;
  logic [SW-1:0] best_r, best_nxt;
  logic [PW-1:0] bestp_r, bestp_nxt;
  logic          found_r, found_nxt;
  link_t         lk_r, lk_nxt;
  logic [SW-1:0] head_r [PRIORITY_LEVELS];
  logic [PRIORITY_LEVELS-1:0] ne_r, ne_nxt;
  logic          hd_we;
  logic [PW-1:0] hd_wa;
  logic [SW-1:0] hd_wd;
  logic [PW-1:0] lv_r, lv_nxt;
  logic [SW-1:0] run_r, run_nxt;
  logic          runp_r, runp_nxt;
  logic [31:0]   tid_r, tid_nxt;
  logic          ov_r, ov_nxt;
  logic [2:0]    ost_r, ost_nxt;
  logic [4:0]    osl_r, osl_nxt;
  logic [31:0]   otid_r, otid_nxt;

  logic [SW-1:0] idx_s;
  logic          acc;
  logic [PW-1:0] preq;

  assign idx_s = idx_r[SW-1:0];
  assign in_ready = (state_r == S_IDLE) && !clr_r && !ov_r;
  assign acc = in_valid && in_ready;
  assign preq = (32'(in_priority_req) >= PRIORITY_LEVELS) ? PW'(PRIORITY_LEVELS - 1)
                                                          : PW'(in_priority_req);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      clr_r   <= 1'b1;
      ne_r    <= '0;
      run_r   <= '0;
      runp_r  <= 1'b0;
      tid_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      clr_r   <= clr_nxt;
      ne_r    <= ne_nxt;
      run_r   <= run_nxt;
      runp_r  <= runp_nxt;
      tid_r   <= tid_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt; prio_r <= prio_nxt; stime_r <= stime_nxt; sema_r <= sema_nxt;
    s_r <= s_nxt; t_r <= t_nxt; start_r <= start_nxt; best_r <= best_nxt;
    bestp_r <= bestp_nxt; found_r <= found_nxt; lk_r <= lk_nxt; lv_r <= lv_nxt;
    ost_r <= ost_nxt; osl_r <= osl_nxt; otid_r <= otid_nxt;
    if (hd_we) head_r[hd_wa] <= hd_wd;
  end

  always_comb begin
    state_nxt = state_r; idx_nxt = idx_r; clr_nxt = clr_r;
    mode_nxt = mode_r; prio_nxt = prio_r; stime_nxt = stime_r; sema_nxt = sema_r;
    s_nxt = s_r; t_nxt = t_r; start_nxt = start_r; best_nxt = best_r;
    bestp_nxt = bestp_r; found_nxt = found_r; lk_nxt = lk_r; lv_nxt = lv_r;
    ne_nxt = ne_r; run_nxt = run_r; runp_nxt = runp_r; tid_nxt = tid_r;
    ov_nxt = ov_r; ost_nxt = ost_r; osl_nxt = osl_r; otid_nxt = otid_r;
    a_we = 1'b0; a_wa = idx_s; a_wd = a_rd; a_ra = idx_s;
    l_we = 1'b0; l_wa = s_r; l_wd = lk_r; l_ra = s_r;
    hd_we = 1'b0; hd_wa = prio_r; hd_wd = s_r;

    if (ov_r && out_ready) ov_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (clr_r) begin
          a_we = 1'b1;
          a_wd = '0;
          idx_nxt = idx_r + 1'b1;
          if (idx_s == SW'(THREAD_SLOTS - 1)) begin
            clr_nxt = 1'b0;
            idx_nxt = '0;
          end
        end else if (acc) begin
          mode_nxt = in_mode; prio_nxt = preq; stime_nxt = in_sleep_time;
          sema_nxt = in_sema_id;
          ost_nxt = ST_OK; osl_nxt = '0; otid_nxt = '0;
          idx_nxt = '0; found_nxt = 1'b0; lv_nxt = '0;
          a_ra = run_r;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (mode_r)
          M_ADD, M_UNBLOCK, M_TICK: begin
            a_ra = '0;
            state_nxt = (mode_r == M_ADD) ? S_ADD_SCAN :
                        (mode_r == M_TICK) ? S_TICK_RD : S_UNB_SCAN;
            idx_nxt = '0;
          end
          M_KILL, M_SLEEP, M_BLOCK: begin
            if (!runp_r) begin
              ost_nxt = ST_NORUN;
              state_nxt = S_DONE;
            end else begin
              s_nxt = run_r;
              l_ra = run_r;
              a_ra = run_r;
              state_nxt = (mode_r == M_KILL) ? S_KILL_RD : S_RUN_RD;
            end
          end
          M_SCHED: state_nxt = S_SCH_LVL;
          default: state_nxt = S_DONE;
        endcase
      end
      // a_rd holds the entry of slot idx; read the next one ahead
      S_ADD_SCAN: begin
        a_ra = idx_s + 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (!a_rd.used) begin
          s_nxt = idx_s;
          a_we = 1'b1; a_wa = idx_s;
          a_wd = '{used: 1'b1, prio: prio_r, sleep: '0, blk: '0};
          otid_nxt = tid_r; tid_nxt = tid_r + 1'b1;
          osl_nxt = 5'(idx_s);
          if (!runp_r) begin
            run_nxt = idx_s; runp_nxt = 1'b1;
          end
          if (!ne_r[prio_r]) begin
            ne_nxt[prio_r] = 1'b1;
            hd_we = 1'b1; hd_wd = idx_s;
            l_we = 1'b1; l_wa = idx_s;
            l_wd = '{nxt: idx_s, prv: idx_s};
            state_nxt = S_DONE;
          end else begin
            l_ra = head_r[prio_r];
            state_nxt = S_ADD_HEAD;
          end
        end else if (idx_s == SW'(THREAD_SLOTS - 1)) begin
          ost_nxt = ST_FULL;
          state_nxt = S_DONE;
        end
      end
      S_ADD_HEAD: begin
        t_nxt = l_rd.prv;
        l_we = 1'b1; l_wa = head_r[prio_r];
        l_wd = '{nxt: l_rd.nxt, prv: s_r};
        if (l_rd.prv == head_r[prio_r]) l_wd.nxt = s_r;
        l_ra = l_rd.prv;
        state_nxt = S_ADD_TAIL;
      end
      S_ADD_TAIL: begin
        l_we = 1'b1; l_wa = t_r;
        l_wd = '{nxt: s_r, prv: l_rd.prv};
        if (t_r == head_r[prio_r]) l_wd.prv = s_r;
        state_nxt = S_ADD_LINK;
      end
      S_ADD_LINK: begin
        l_we = 1'b1; l_wa = s_r;
        l_wd = '{nxt: head_r[prio_r], prv: t_r};
        state_nxt = S_DONE;
      end
      S_KILL_RD: begin
        lk_nxt = l_rd;
        prio_nxt = a_rd.prio;
        a_we = 1'b1; a_wa = s_r; a_wd = '0;
        osl_nxt = 5'(s_r);
        run_nxt = '0; runp_nxt = 1'b0;
        if (l_rd.nxt == s_r) begin
          ne_nxt[a_rd.prio] = 1'b0;
          state_nxt = S_DONE;
        end else begin
          if (head_r[a_rd.prio] == s_r) begin
            hd_we = 1'b1; hd_wa = a_rd.prio; hd_wd = l_rd.nxt;
          end
          l_ra = l_rd.prv;
          state_nxt = S_KILL_LINK;
        end
      end
      S_KILL_LINK: begin
        if (idx_r == '0) begin
          l_we = 1'b1; l_wa = lk_r.prv;
          l_wd = '{nxt: lk_r.nxt, prv: (lk_r.prv == lk_r.nxt) ? lk_r.prv : l_rd.prv};
          l_ra = lk_r.nxt;
          idx_nxt = (SW+1)'(1);
        end else begin
          l_we = 1'b1; l_wa = lk_r.nxt;
          l_wd = '{nxt: (lk_r.prv == lk_r.nxt) ? lk_r.nxt : l_rd.nxt, prv: lk_r.prv};
          state_nxt = S_DONE;
        end
      end
      S_RUN_RD: begin
        a_wa = s_r; a_wd = a_rd;
        if (mode_r == M_SLEEP) begin
          a_we = 1'b1; a_wd.sleep = stime_r;
        end else if (a_rd.blk != '0) begin
          ost_nxt = ST_BLOCKED;
        end else begin
          a_we = 1'b1; a_wd.blk = sema_r;
        end
        state_nxt = S_DONE;
      end
      // a_rd holds the entry of slot idx; read the next one ahead
      S_UNB_SCAN: begin
        a_ra = idx_s + 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (a_rd.used && a_rd.blk == sema_r && sema_r != '0 &&
            (!found_r || a_rd.prio < bestp_r)) begin
          found_nxt = 1'b1; best_nxt = idx_s; bestp_nxt = a_rd.prio;
        end
        if (idx_s == SW'(THREAD_SLOTS - 1)) begin
          state_nxt = S_UNB_WR;
          a_ra = best_nxt;
          s_nxt = best_nxt;
        end
      end
      S_UNB_WR: begin
        if (!found_r) begin
          ost_nxt = ST_NONE;
          state_nxt = S_DONE;
        end else if (idx_r != '1) begin
          idx_nxt = '1;
        end else begin
          a_we = 1'b1; a_wa = s_r; a_wd = a_rd; a_wd.blk = '0;
          osl_nxt = 5'(s_r);
          state_nxt = S_DONE;
        end
        a_ra = s_r;
      end
      S_TICK_RD: begin
        state_nxt = S_TICK_WR;
      end
      S_TICK_WR: begin
        a_we = 1'b1; a_wd = a_rd;
        if (a_rd.sleep != '0) a_wd.sleep = a_rd.sleep - 1'b1;
        idx_nxt = idx_r + 1'b1;
        a_ra = idx_s + 1'b1;
        state_nxt = (idx_r == (SW+1)'(THREAD_SLOTS - 1)) ? S_DONE : S_TICK_RD;
      end
      S_SCH_LVL: begin
        if (!ne_r[lv_r]) begin
          lv_nxt = lv_r + 1'b1;
          if (lv_r == PW'(PRIORITY_LEVELS - 1)) begin
            ost_nxt = ST_NORUN;
            state_nxt = S_DONE;
          end
        end else begin
          start_nxt = head_r[lv_r]; s_nxt = head_r[lv_r];
          a_ra = head_r[lv_r]; l_ra = head_r[lv_r];
          idx_nxt = '0;
          state_nxt = S_SCH_RD;
        end
      end
      S_SCH_RD: begin
        a_ra = s_r;
        state_nxt = S_SCH_CHK;
      end
      S_SCH_CHK: begin
        if (a_rd.sleep == '0 && a_rd.blk == '0) begin
          run_nxt = s_r; runp_nxt = 1'b1;
          hd_we = 1'b1; hd_wa = lv_r; hd_wd = l_rd.nxt;
          state_nxt = S_DONE;
        end else if (l_rd.nxt == start_r || idx_r == (SW+1)'(THREAD_SLOTS - 1)) begin
          lv_nxt = lv_r + 1'b1;
          state_nxt = S_SCH_LVL;
          if (lv_r == PW'(PRIORITY_LEVELS - 1)) begin
            ost_nxt = ST_NORUN;
            state_nxt = S_DONE;
          end
        end else begin
          s_nxt = l_rd.nxt; a_ra = l_rd.nxt; l_ra = l_rd.nxt;
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_SCH_RD;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid         = ov_r;
  assign out_status        = ost_r;
  assign out_slot          = osl_r;
  assign out_thread_id     = otid_r;
  assign out_running_slot  = runp_r ? 5'(run_r) : 5'd0;
  assign out_running_valid = runp_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> state_r == S_DISPATCH)
    else $error("item taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r && $stable(ost_r) && $stable(osl_r))
    else $error("result dropped");
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !in_ready)
    else $error("item taken during clear pass");
endmodule

// ----- sim/prrs_checker.sv -----
// ----------------------------------------------------------------------------
// prrs_checker
// Watches the command and result channels of the scheduler, keeps its own
// copy of the slot table and priority rings, predicts each result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module prrs_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [2:0]  in_priority_req,
  input  logic [30:0] in_sleep_time,
  input  logic [7:0]  in_sema_id,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_status,
  input  logic [4:0]  out_slot,
  input  logic [31:0] out_thread_id,
  input  logic [4:0]  out_running_slot,
  input  logic        out_running_valid,
  output int          fail_count,
  output int          pending_count
);
  import prrs_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [4:0]  slot;
    logic [31:0] thread_id;
    logic [4:0]  running_slot;
    logic        running_valid;
  } sched_result_t;

  logic        used_q    [THREAD_SLOTS];
  logic [2:0]  prio_q    [THREAD_SLOTS];
  logic [30:0] sleep_q   [THREAD_SLOTS];
  logic [7:0]  blocked_q [THREAD_SLOTS];
  logic [4:0]  next_q    [THREAD_SLOTS];
  logic [4:0]  prev_q    [THREAD_SLOTS];
  logic [4:0]  head_q    [PRIORITY_LEVELS];
  logic        nonempty_q[PRIORITY_LEVELS];
  logic [4:0]  run_slot;
  logic        run_present;
  logic [31:0] tid_next;

  sched_result_t expected_results[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic sched_result_t schedule_command(input mode_t mode,
      input logic [2:0] prio, input logic [30:0] stime, input logic [7:0] sema);
    sched_result_t r;
    int s, best, lv, steps;
    logic [4:0] h, t, n, b, cur, start;
    logic [2:0] p;
    logic found;
    r = '0;
    case (mode)
      M_ADD: begin
        s = THREAD_SLOTS;
        for (int i = THREAD_SLOTS - 1; i >= 0; i--) if (!used_q[i]) s = i;
        if (s == THREAD_SLOTS) begin
          r.status = ST_FULL;
        end else begin
          used_q[s] = 1'b1;
          prio_q[s] = prio;
          sleep_q[s] = '0;
          blocked_q[s] = '0;
          r.thread_id = tid_next;
          tid_next++;
          if (!nonempty_q[prio]) begin
            nonempty_q[prio] = 1'b1;
            head_q[prio] = 5'(s);
            next_q[s] = 5'(s);
            prev_q[s] = 5'(s);
          end else begin
            h = head_q[prio];
            t = prev_q[h];
            prev_q[s] = t;
            next_q[s] = h;
            prev_q[h] = 5'(s);
            next_q[t] = 5'(s);
          end
          if (!run_present) begin
            run_slot = 5'(s);
            run_present = 1'b1;
          end
          r.slot = 5'(s);
        end
      end
      M_KILL, M_SLEEP, M_BLOCK: begin
        if (!run_present) begin
          r.status = ST_NORUN;
        end else if (mode == M_KILL) begin
          p = prio_q[run_slot];
          n = next_q[run_slot];
          b = prev_q[run_slot];
          if (n == run_slot) begin
            nonempty_q[p] = 1'b0;
          end else begin
            if (head_q[p] == run_slot) head_q[p] = n;
            next_q[b] = n;
            prev_q[n] = b;
          end
          used_q[run_slot] = 1'b0;
          sleep_q[run_slot] = '0;
          blocked_q[run_slot] = '0;
          r.slot = run_slot;
          run_slot = '0;
          run_present = 1'b0;
        end else if (mode == M_SLEEP) begin
          sleep_q[run_slot] = stime;
        end else if (blocked_q[run_slot] != 0) begin
          r.status = ST_BLOCKED;
        end else begin
          blocked_q[run_slot] = sema;
        end
      end
      M_UNBLOCK: begin
        best = THREAD_SLOTS;
        if (sema != 0)
          for (int i = 0; i < THREAD_SLOTS; i++)
            if (used_q[i] && blocked_q[i] == sema &&
                (best == THREAD_SLOTS || prio_q[i] < prio_q[best])) best = i;
        if (best == THREAD_SLOTS) begin
          r.status = ST_NONE;
        end else begin
          blocked_q[best] = '0;
          r.slot = 5'(best);
        end
      end
      M_TICK: begin
        for (int i = 0; i < THREAD_SLOTS; i++) if (sleep_q[i] != 0) sleep_q[i]--;
      end
      M_SCHED: begin
        found = 1'b0;
        for (lv = 0; lv < PRIORITY_LEVELS && !found; lv++) begin
          if (nonempty_q[lv]) begin
            start = head_q[lv];
            cur = start;
            for (steps = 0; steps < THREAD_SLOTS; steps++) begin
              if (sleep_q[cur] == 0 && blocked_q[cur] == 0) begin
                run_slot = cur;
                run_present = 1'b1;
                head_q[lv] = next_q[cur];
                found = 1'b1;
                break;
              end
              cur = next_q[cur];
              if (cur == start) break;
            end
          end
        end
        if (!found) r.status = ST_NORUN;
      end
      default: ;
    endcase
    r.running_slot = run_present ? run_slot : 5'd0;
    r.running_valid = run_present;
    return r;
  endfunction

  always @(posedge clk) begin
    sched_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < THREAD_SLOTS; i++) begin
        used_q[i] = 1'b0; sleep_q[i] = '0; blocked_q[i] = '0;
        prio_q[i] = '0; next_q[i] = '0; prev_q[i] = '0;
      end
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
        head_q[i] = '0; nonempty_q[i] = 1'b0;
      end
      run_slot = '0;
      run_present = 1'b0;
      tid_next = '0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(schedule_command(in_mode, in_priority_req,
                                                    in_sleep_time, in_sema_id));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result item at %0t", $time);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", 32'(out_status), 32'(want.status));
          if (out_slot !== want.slot)
            report_mismatch("slot", 32'(out_slot), 32'(want.slot));
          if (out_thread_id !== want.thread_id)
            report_mismatch("thread_id", out_thread_id, want.thread_id);
          if (out_running_slot !== want.running_slot)
            report_mismatch("running_slot", 32'(out_running_slot),
                            32'(want.running_slot));
          if (out_running_valid !== want.running_valid)
            report_mismatch("running_valid", 32'(out_running_valid),
                            32'(want.running_valid));
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

// ----- sim/tb_priority_round_robin_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// tb_priority_round_robin_scheduler_top
// Drives scheduler commands with random gaps and result stalls: a directed
// opening over every command, with empty and full table cases, then random
// command mixes that fill the table, block, sleep, tick and schedule. A
// checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_priority_round_robin_scheduler_top;
  import prrs_pkg::*;

  localparam int CMD_COUNT = 1700;
  localparam int CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_mode;
  logic [2:0]  in_priority_req;
  logic [30:0] in_sleep_time;
  logic [7:0]  in_sema_id;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [4:0]  out_slot;
  logic [31:0] out_thread_id;
  logic [4:0]  out_running_slot;
  logic        out_running_valid;
  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;
  logic        calm;

  priority_round_robin_scheduler_top uut (.*);

  prrs_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk)
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 26);

  task automatic send_command(input mode_t mode, input logic [2:0] prio,
                              input logic [30:0] stime, input logic [7:0] sema);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 26) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_priority_req <= prio;
    in_sleep_time <= stime;
    in_sema_id <= sema;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random;
    int pick;
    mode_t mode;
    logic [30:0] stime;
    pick = $urandom_range(99);
    if (pick < 22) mode = M_ADD;
    else if (pick < 30) mode = M_KILL;
    else if (pick < 40) mode = M_SLEEP;
    else if (pick < 50) mode = M_BLOCK;
    else if (pick < 62) mode = M_UNBLOCK;
    else if (pick < 75) mode = M_TICK;
    else if (pick < 98) mode = M_SCHED;
    else mode = M_NOP;
    case ($urandom_range(9))
      0: stime = 31'($urandom);
      1: stime = 31'h7fffffff;
      default: stime = 31'($urandom_range(4));
    endcase
    send_command(mode, 3'($urandom_range(7)), stime,
                 ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3)));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = M_ADD;
    in_priority_req = '0;
    in_sleep_time = '0;
    in_sema_id = '0;
    calm = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    send_command(M_KILL, 3'd0, 31'd0, 8'd0);
    send_command(M_SLEEP, 3'd0, 31'd5, 8'd0);
    send_command(M_BLOCK, 3'd0, 31'd0, 8'd9);
    send_command(M_SCHED, 3'd0, 31'd0, 8'd0);
    send_command(M_UNBLOCK, 3'd0, 31'd0, 8'd0);
    send_command(M_ADD, 3'd7, 31'd0, 8'd0);
    send_command(M_ADD, 3'd0, 31'd0, 8'd0);
    send_command(M_ADD, 3'd7, 31'd0, 8'd0);
    send_command(M_SLEEP, 3'd0, 31'h7fffffff, 8'd0);
    send_command(M_BLOCK, 3'd0, 31'd0, 8'hff);
    send_command(M_BLOCK, 3'd0, 31'd0, 8'h01);
    send_command(M_SCHED, 3'd0, 31'd0, 8'd0);
    send_command(M_BLOCK, 3'd0, 31'd0, 8'h00);
    send_command(M_UNBLOCK, 3'd0, 31'd0, 8'hff);
    send_command(M_UNBLOCK, 3'd0, 31'd0, 8'hff);
    send_command(M_TICK, 3'd0, 31'd0, 8'd0);
    send_command(M_NOP, 3'd0, 31'd0, 8'd0);
    send_command(M_SCHED, 3'd0, 31'd0, 8'd0);
    send_command(M_KILL, 3'd0, 31'd0, 8'd0);
    for (int i = 0; i < 34; i++) send_command(M_ADD, 3'($urandom_range(7)), 31'd0, 8'd0);
    for (int i = 0; i < 6; i++) begin
      send_command(M_SCHED, 3'd0, 31'd0, 8'd0);
      send_command(M_KILL, 3'd0, 31'd0, 8'd0);
    end
    for (int i = 0; i < CMD_COUNT; i++) begin
      calm = (i >= 600 && i < 800);
      send_random();
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
